[design/scs_pkg.sv]
// Shared types and constants for the shortest common supersequence block.
`timescale 1ns / 1ps
package scs_pkg;
  localparam int MaxLen = 32;
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int IdxW = $clog2(MaxLen);
  localparam int OutDepth = 2 * MaxLen;
  localparam int OutW = $clog2(OutDepth + 1);
  localparam int DirW = 2 * IdxW;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_UP   = 2'd2,
    DIR_DIAG = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_TRACE, ST_EMIT, ST_EMPTY
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last;
    logic       empty_res;
    logic       truncated;
  } out_beat_t;
endpackage

[design/scs_if.sv]
// Valid/ready channel interfaces for input and result beats.
`timescale 1ns / 1ps
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] symbol;
  modport source (output valid, cmd, symbol, input ready);
  modport sink (input valid, cmd, symbol, output ready);
endinterface

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last;
  logic       empty_res;
  logic       truncated;
  modport source (output valid, out_symbol, last, empty_res, truncated, input ready);
  modport sink (input valid, out_symbol, last, empty_res, truncated, output ready);
endinterface

[design/scs_front.sv]
// Front end: accepts input beats, drops unused codes, queues them for the engine.
`timescale 1ns / 1ps
module scs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  scs_in_if.sink             in_if,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output scs_pkg::in_beat_t  q_data_o
);
  localparam int Depth = 2;
  scs_pkg::in_beat_t mem_q [Depth];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready && (in_if.cmd != scs_pkg::CMD_NOP);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? ~wr_q : wr_q;
    rd_d = (q_pop_i && q_valid_o) ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{cmd: in_if.cmd, symbol: in_if.symbol};
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !(q_pop_i && q_valid_o)) else $error("pop from empty");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_if.ready) else $error("ready while full");
`endif
endmodule

[design/scs_engine.sv]
// Back end: string stores, LCS table fill, traceback and result emission.
`timescale 1ns / 1ps
module scs_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  scs_pkg::in_beat_t  q_data_i,
  scs_out_if.source          out_if
);
  localparam int LW = scs_pkg::LenW;
  localparam int IW = scs_pkg::IdxW;
  localparam int OW = scs_pkg::OutW;
  localparam int BW = $clog2(scs_pkg::OutDepth);

  logic [7:0] str_a_q [scs_pkg::MaxLen];
  logic [7:0] str_b_q [scs_pkg::MaxLen];
  logic [1:0] dir_mem [scs_pkg::MaxLen * scs_pkg::MaxLen];
  logic [7:0] obuf [scs_pkg::OutDepth];
  // column zero of the LCS row is always zero, so only columns 1..MaxLen are kept
  logic [LW-1:0] row_q [scs_pkg::MaxLen];

  scs_pkg::state_e st_q, st_d;
  logic [LW-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic ovf_q, ovf_d, tr_q, tr_d;
  logic [LW-1:0] r_q, r_d, c_q, c_d;
  logic [LW-1:0] diag_q, diag_d;
  logic [OW-1:0] n_q, n_d;
  logic [1:0] dir_rd_q;
  logic dir_ok_q, dir_ok_d;
  logic [7:0] obuf_rd_q;
  logic [BW-1:0] obuf_ra;

  // output register
  logic ov_q, ov_d;
  scs_pkg::out_beat_t ob_q, ob_d;

  logic [7:0] sa, sb;
  logic [LW-1:0] up, left, val;
  logic [1:0] dcode;
  logic row_we, dir_we, obuf_we, row_clr;
  logic [7:0] obuf_wd;
  logic [scs_pkg::DirW-1:0] dir_wa, dir_ra;

  assign sa = str_a_q[IW'(r_q - LW'(1))];
  assign sb = str_b_q[IW'(c_q - LW'(1))];
  assign up = row_q[IW'(c_q - LW'(1))];
  assign left = (c_q == LW'(1)) ? '0 : row_q[IW'(c_q - LW'(2))];
  assign dir_wa = {IW'(r_q - LW'(1)), IW'(c_q - LW'(1))};
  assign dir_ra = {IW'(r_d - LW'(1)), IW'(c_d - LW'(1))};
  // registered buffer read tracks the entry that EMIT sends next
  assign obuf_ra = BW'(n_d - OW'(1));

  always_comb begin
    if (sa == sb) begin
      val = diag_q + LW'(1); dcode = scs_pkg::DIR_DIAG;
    end else if (left > up) begin
      val = left; dcode = scs_pkg::DIR_LEFT;
    end else begin
      val = up; dcode = scs_pkg::DIR_UP;
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.out_symbol = ob_q.out_symbol;
  assign out_if.last = ob_q.last;
  assign out_if.empty_res = ob_q.empty_res;
  assign out_if.truncated = ob_q.truncated;

  always_comb begin
    logic oslot;
    oslot = !ov_q || out_if.ready;
    st_d = st_q; len_a_d = len_a_q; len_b_d = len_b_q; ovf_d = ovf_q; tr_d = tr_q;
    r_d = r_q; c_d = c_q; diag_d = diag_q; n_d = n_q; dir_ok_d = 1'b0;
    ov_d = ov_q && !out_if.ready; ob_d = ob_q;
    q_pop_o = 1'b0; row_we = 1'b0; dir_we = 1'b0; obuf_we = 1'b0; row_clr = 1'b0;
    obuf_wd = 8'd0;
    unique case (st_q)
      scs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_data_i.cmd)
            scs_pkg::CMD_LOAD_A: begin
              q_pop_o = 1'b1;
              if (len_a_q < LW'(scs_pkg::MaxLen)) len_a_d = len_a_q + LW'(1);
              else ovf_d = 1'b1;
            end
            scs_pkg::CMD_LOAD_B: begin
              q_pop_o = 1'b1;
              if (len_b_q < LW'(scs_pkg::MaxLen)) len_b_d = len_b_q + LW'(1);
              else ovf_d = 1'b1;
            end
            scs_pkg::CMD_RUN: begin
              q_pop_o = 1'b1;
              tr_d = ovf_q; row_clr = 1'b1; diag_d = '0; n_d = '0;
              r_d = LW'(1); c_d = LW'(1);
              if (len_a_q == '0 && len_b_q == '0) st_d = scs_pkg::ST_EMPTY;
              else if (len_a_q == '0 || len_b_q == '0) begin
                r_d = len_a_q; c_d = len_b_q; st_d = scs_pkg::ST_TRACE;
              end else st_d = scs_pkg::ST_FILL;
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      scs_pkg::ST_FILL: begin
        // one cell a cycle, row-major
        row_we = 1'b1; dir_we = 1'b1;
        if (c_q == len_b_q) begin
          c_d = LW'(1); diag_d = '0;
          if (r_q == len_a_q) begin
            r_d = len_a_q; c_d = len_b_q; st_d = scs_pkg::ST_TRACE;
          end else r_d = r_q + LW'(1);
        end else begin
          c_d = c_q + LW'(1); diag_d = up;
        end
      end
      scs_pkg::ST_TRACE: begin
        // dir read is registered: a step inside the table first waits for the read, flagged by dir_ok
        if (r_q == '0 && c_q == '0) begin
          st_d = scs_pkg::ST_EMIT;
        end else if (r_q == '0) begin
          obuf_we = 1'b1; obuf_wd = sb; c_d = c_q - LW'(1); n_d = n_q + OW'(1);
        end else if (c_q == '0) begin
          obuf_we = 1'b1; obuf_wd = sa; r_d = r_q - LW'(1); n_d = n_q + OW'(1);
        end else if (!dir_ok_q) begin
          dir_ok_d = 1'b1;
        end else begin
          obuf_we = 1'b1; n_d = n_q + OW'(1);
          if (dir_rd_q == scs_pkg::DIR_DIAG) begin
            obuf_wd = sa; r_d = r_q - LW'(1); c_d = c_q - LW'(1);
          end else if (dir_rd_q == scs_pkg::DIR_LEFT) begin
            obuf_wd = sb; c_d = c_q - LW'(1);
          end else begin
            obuf_wd = sa; r_d = r_q - LW'(1);
          end
        end
      end
      scs_pkg::ST_EMIT: begin
        if (oslot) begin
          ov_d = 1'b1;
          ob_d.out_symbol = obuf_rd_q;
          ob_d.last = (n_q == OW'(1)); ob_d.empty_res = 1'b0; ob_d.truncated = tr_q;
          n_d = n_q - OW'(1);
          if (n_q == OW'(1)) begin
            st_d = scs_pkg::ST_IDLE; len_a_d = '0; len_b_d = '0; ovf_d = 1'b0;
          end
        end
      end
      scs_pkg::ST_EMPTY: begin
        if (oslot) begin
          ov_d = 1'b1;
          ob_d = '{out_symbol: 8'd0, last: 1'b1, empty_res: 1'b1, truncated: tr_q};
          st_d = scs_pkg::ST_IDLE; len_a_d = '0; len_b_d = '0; ovf_d = 1'b0;
        end
      end
      default: st_d = scs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= scs_pkg::ST_IDLE;
      len_a_q <= '0; len_b_q <= '0; ovf_q <= 1'b0; ov_q <= 1'b0; dir_ok_q <= 1'b0;
    end else begin
      st_q <= st_d;
      len_a_q <= len_a_d; len_b_q <= len_b_d; ovf_q <= ovf_d; ov_q <= ov_d;
      dir_ok_q <= dir_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tr_q <= tr_d; r_q <= r_d; c_q <= c_d; diag_q <= diag_d; n_q <= n_d; ob_q <= ob_d;
    if (st_q == scs_pkg::ST_IDLE && q_valid_i) begin
      if (q_data_i.cmd == scs_pkg::CMD_LOAD_A && len_a_q < LW'(scs_pkg::MaxLen))
        str_a_q[IW'(len_a_q)] <= q_data_i.symbol;
      if (q_data_i.cmd == scs_pkg::CMD_LOAD_B && len_b_q < LW'(scs_pkg::MaxLen))
        str_b_q[IW'(len_b_q)] <= q_data_i.symbol;
    end
    for (int i = 0; i < scs_pkg::MaxLen; i++) begin
      if (row_clr) row_q[i] <= '0;
      else if (row_we && c_q == LW'(i + 1)) row_q[i] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obuf_we) obuf[BW'(n_q)] <= obuf_wd;
    obuf_rd_q <= obuf[obuf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dcode;
    dir_rd_q <= dir_mem[dir_ra];
  end

`ifndef SYNTHESIS
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == scs_pkg::ST_EMIT) |-> (n_q != '0)) else $error("emit with empty buffer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> (ov_q && $stable(ob_q))) else $error("result lost");
  a_lens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_a_q <= LW'(scs_pkg::MaxLen) && len_b_q <= LW'(scs_pkg::MaxLen))
    else $error("length overflow");
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((st_q == scs_pkg::ST_EMIT && n_q == OW'(1)) || st_q == scs_pkg::ST_EMPTY) &&
     (!ov_q || out_if.ready)) |=> (len_a_q == '0 && len_b_q == '0 && !ovf_q))
    else $error("lengths not cleared");
`endif
endmodule

[design/shortest_common_supersequence_core.sv]
// Top level of the shortest common supersequence block.
// Usage:
//  in_if carries beats of cmd and symbol. cmd 0 appends symbol to string A,
//  cmd 1 to string B, cmd 2 runs; cmd 3 is dropped. Up to 32 symbols per
//  string are kept; more set the truncated flag of the next run.
//  A run gives one out_if beat per supersequence symbol in forward order,
//  last set on the final beat; with both strings empty a single beat with
//  empty_res set. After the run lengths and the truncation flag clear.
// Timing:
//  Loads are taken by the engine while it is idle. A run fills the LCS table one cell
//  per cycle, then traces back, where each step inside the table waits for
//  the registered direction memory read, then emits one beat per cycle while
//  the receiver is ready.
//  A two-entry queue lets loads be accepted while the engine is busy.
// Reset clears lengths and flags; stores need no clearing. A stalled
//  receiver holds the output register and pauses emission.
`timescale 1ns / 1ps
module shortest_common_supersequence_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  scs_in_if.sink    in_if,
  scs_out_if.source out_if
);
  logic q_valid, q_pop;
  scs_pkg::in_beat_t q_data;

  scs_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  scs_engine u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data), .out_if
  );
endmodule
